/* rtl/wildcard_byte_pattern_scanner_assert.svh */
// Assertion macros shared by the scanner's RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define WBPS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define WBPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps: next-cycle check failed");

`endif

/* rtl/wbps_pkg.sv */
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int REG_PATTERNS = 16;
    localparam int RESULT_OFFSET_W = 32;

    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_WILD     = 2'd2,
        REG_LENGTH   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] pat_low;
        logic [63:0] pat_high;
        logic [15:0] wild_mask;
        logic [4:0]  length;
    } cfg_t;

    // What one compare cell checks against.
    typedef struct packed {
        logic       care;
        logic [7:0] exp_byte;
    } cell_cmp_t;

endpackage

/* rtl/wbps_cell.sv */
// One window cell: holds a byte, passes it on, compares it against its pattern byte.
module wbps_cell
    import wbps_pkg::*;
(
    input  logic      clk,
    input  logic      shift_en,
    input  logic [7:0] byte_in,
    input  cell_cmp_t cmp,
    output logic [7:0] byte_out,
    output logic      hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !cmp.care || (byte_reg == cmp.exp_byte);

endmodule

/* rtl/wbps_cfg.sv */
// APB register file of the scanner: pattern, wildcard mask and length.
module wbps_cfg
    import wbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_PAT_LOW:  cfg_next.pat_low   = pwdata;
                REG_PAT_HIGH: cfg_next.pat_high  = pwdata;
                REG_WILD:     cfg_next.wild_mask = pwdata[15:0];
                REG_LENGTH:   cfg_next.length    = pwdata[4:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pat_low   <= '0;
            cfg_reg.pat_high  <= '0;
            cfg_reg.wild_mask <= '0;
            cfg_reg.length    <= 5'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_PAT_LOW:  prdata = cfg_reg.pat_low;
            REG_PAT_HIGH: prdata = cfg_reg.pat_high;
            REG_WILD:     prdata = {48'd0, cfg_reg.wild_mask};
            REG_LENGTH:   prdata = {59'd0, cfg_reg.length};
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/wildcard_byte_pattern_scanner.sv */
// Top level of the wildcard byte pattern scanner: cell chain, byte counter, result register.
// The scanner takes a memory image one byte per word on the item channel and reports,
// once per image, where a configured pattern of up to MAX_PATTERN_BYTES bytes first
// matches; pattern bytes flagged in the wildcard mask match any byte. At the first match
// it returns found = 1 with the offset of the match's first byte; if the image ends with
// no match it returns found = 0 and offset 0 on the word of the last byte. The last byte
// always rearms the scanner for the next image, and bytes after a match are swallowed
// until then. It takes one byte every cycle while the item channel is not stalled: the
// recent bytes sit in a chain of cells that each compare their byte against the pattern
// byte aligned to them, and a result is registered as the byte that produced it is taken.
// The item channel stalls only while that output register is full and stalled itself.
// Program the registers over APB (64-bit, at byte addresses 0, 8, 16, 24) only while the
// scanner is idle. Pattern lengths of 0 are taken as 1 and lengths above
// MAX_PATTERN_BYTES as MAX_PATTERN_BYTES. The byte counter saturates at OFFSET_BITS bits.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    // image byte stream
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [7:0]                 image_byte,
    input  logic                       last_byte,
    // results
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic                       found,
    output logic [RESULT_OFFSET_W-1:0] match_offset
);

    localparam int LEN_W     = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int WIN_CELLS = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;

    cfg_t cfg;

    wbps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------------------------------------------------------------------------
    // Handshake: accept a byte whenever the result register is free or draining.
    // ---------------------------------------------------------------------------------
    logic item_accept;
    logic result_valid_reg, result_valid_next;
    logic found_reg, found_next;
    logic [RESULT_OFFSET_W-1:0] offset_reg, offset_next;

    assign item_stall  = result_valid_reg && result_stall;
    assign item_accept = item_valid && !item_stall;

    // ---------------------------------------------------------------------------------
    // Effective length: zero counts as one, clamp to the chain length.
    // ---------------------------------------------------------------------------------
    logic [LEN_W-1:0] len_c;

    always_comb
    begin
        if (cfg.length == 5'd0)
        begin
            len_c = LEN_W'(1);
        end
        else if (7'(cfg.length) > 7'(MAX_PATTERN_BYTES))
        begin
            len_c = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_c = LEN_W'(cfg.length);
        end
    end

    // ---------------------------------------------------------------------------------
    // Align the pattern to byte age: age 0 is the incoming byte and checks the last
    // pattern byte in use, age a checks pattern byte len-1-a. Ages past the length
    // do not care. Pattern positions above the register bits match zero, never wild.
    // ---------------------------------------------------------------------------------
    logic [7:0] pat_arr [REG_PATTERNS];
    cell_cmp_t  cmp [MAX_PATTERN_BYTES];

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            pat_arr[j]     = cfg.pat_low[8*j +: 8];
            pat_arr[j + 8] = cfg.pat_high[8*j +: 8];
        end
    end

    always_comb
    begin
        logic [6:0] pidx;
        for (int a = 0; a < MAX_PATTERN_BYTES; a++)
        begin
            pidx = 7'(len_c) - 7'(a) - 7'd1;
            if (7'(a) >= 7'(len_c))
            begin
                cmp[a].care     = 1'b0;
                cmp[a].exp_byte = 8'd0;
            end
            else if (pidx < 7'(REG_PATTERNS))
            begin
                cmp[a].care     = !cfg.wild_mask[pidx[3:0]];
                cmp[a].exp_byte = pat_arr[pidx[3:0]];
            end
            else
            begin
                cmp[a].care     = 1'b1;
                cmp[a].exp_byte = 8'd0;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Cell chain: cell k holds the byte of age k+1. Shift on every accepted byte.
    // ---------------------------------------------------------------------------------
    logic [7:0]                   win [WIN_CELLS];
    logic [MAX_PATTERN_BYTES-1:0] hit;

    assign hit[0] = !cmp[0].care || (image_byte == cmp[0].exp_byte);

    for (genvar k = 0; k < MAX_PATTERN_BYTES - 1; k++)
    begin : g_cell
        wbps_cell u_cell (
            .clk      (clk),
            .shift_en (item_accept),
            .byte_in  ((k == 0) ? image_byte : win[(k == 0) ? 0 : k - 1]),
            .cmp      (cmp[k + 1]),
            .byte_out (win[k]),
            .hit      (hit[k + 1])
        );
    end

    // ---------------------------------------------------------------------------------
    // Byte counter and done flag. A match needs len bytes of this image, which also
    // keeps stale bytes from earlier images out of the compare.
    // ---------------------------------------------------------------------------------
    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic                   done_reg, done_next;
    logic [OFFSET_BITS-1:0] len_m1;
    logic [OFFSET_BITS-1:0] start_off;
    logic                   match;

    assign len_m1    = OFFSET_BITS'(len_c) - OFFSET_BITS'(1);
    assign start_off = count_reg - len_m1;
    assign match     = !done_reg && (count_reg >= len_m1) && (&hit);

    always_comb
    begin
        count_next = count_reg;
        done_next  = done_reg;
        if (item_accept)
        begin
            if (last_byte)
            begin
                // rearm for the next image
                count_next = '0;
                done_next  = 1'b0;
            end
            else
            begin
                if (count_reg != {OFFSET_BITS{1'b1}})
                begin
                    count_next = count_reg + OFFSET_BITS'(1);
                end
                if (match)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Result register: load on a match or at the end of an unmatched image, drop when
    // taken downstream.
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        found_next        = found_reg;
        offset_next       = offset_reg;
        if (item_accept && !done_reg && (match || last_byte))
        begin
            result_valid_next = 1'b1;
            found_next        = match;
            offset_next       = match ? RESULT_OFFSET_W'(start_off) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            done_reg         <= done_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign result_valid = result_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
`include "wildcard_byte_pattern_scanner_assert.svh"

    `WBPS_ASSERT_NOW(a_stall_only_when_full, item_stall, result_valid_reg)
    `WBPS_ASSERT_NOW(a_miss_has_zero_offset, result_valid_reg && !found_reg, offset_reg == '0)
    `WBPS_ASSERT_NEXT(a_last_rearms, item_accept && last_byte, (count_reg == '0) && !done_reg)
    `WBPS_ASSERT_NEXT(a_match_done, item_accept && match && !last_byte, done_reg && found_reg)

endmodule

/* bench/tb_top.sv */
// Self-checking testbench of the wildcard byte pattern scanner.
module tb_top
    import wbps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling on the run.
    localparam int CYCLE_LIMIT  = 200000;
    // Extra wait after the last awaited report; the result register is loaded as the byte is taken.
    localparam int SETTLE_CYCLES = 4;
    // Minimum bytes streamed per random phase; eight phases give at least 704 words.
    localparam int PHASE_BYTES  = 88;
    localparam int PHASES       = 8;
    localparam int IDLE_PERCENT = 23;
    // Longest image any test streams.
    localparam int MAX_IMAGE_BYTES = 70;

    typedef struct {
        logic                       found;
        logic [RESULT_OFFSET_W-1:0] offset;
    } scan_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       item_valid = 1'b0;
    logic                       item_stall;
    logic [7:0]                 image_byte = '0;
    logic                       last_byte = 1'b0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic                       found;
    logic [RESULT_OFFSET_W-1:0] match_offset;

    // Shadow of the scanner: register copy, byte history, counter and done flag.
    cfg_t         shadow_cfg;
    logic [7:0]   recent_bytes [0:REG_PATTERNS-2];
    logic [31:0]  bytes_seen;
    logic         match_reported;
    scan_result_t awaited_results[$];
    scan_result_t next_awaited;

    // Set for a stretch of the run in which neither side idles.
    logic calm = 1'b0;
    int   errors = 0;
    int   cycles = 0;

    wildcard_byte_pattern_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .image_byte   (image_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .match_offset (match_offset)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stall the result side about a quarter of the time, except in the calm stretch.
    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Pattern length in force: zero counts as one, anything past REG_PATTERNS is clipped to it.
    function automatic int effective_length();
        if (shadow_cfg.length == 0)
            return 1;
        if (shadow_cfg.length > REG_PATTERNS)
            return REG_PATTERNS;
        return int'(shadow_cfg.length);
    endfunction

    function automatic logic [7:0] pattern_byte_at(input int j);
        if (j < 8)
            return shadow_cfg.pat_low[8*j +: 8];
        return shadow_cfg.pat_high[8*(j-8) +: 8];
    endfunction

    task automatic rearm_shadow();
        foreach (recent_bytes[k])
            recent_bytes[k] = '0;
        bytes_seen = '0;
        match_reported = 1'b0;
    endtask

    // Append a report to the tail of the awaited list.
    task automatic await_report(input scan_result_t r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    // Work out what one accepted byte does to the scan, and queue its report if it makes one.
    task automatic predict_scan(input logic [7:0] b, input logic is_last);
        int           len;
        logic         hit;
        logic [7:0]   seen;
        logic [31:0]  start;
        scan_result_t r;
        // Once a match is out, swallow bytes until the image ends.
        if (match_reported)
        begin
            if (is_last)
                rearm_shadow();
            return;
        end
        len = effective_length();
        // A match needs the current byte plus len-1 earlier ones from this image.
        hit = (bytes_seen >= 32'(len - 1));
        for (int j = 0; j < len; j++)
        begin
            seen = (j == len - 1) ? b : recent_bytes[len - 2 - j];
            if (!shadow_cfg.wild_mask[j] && seen != pattern_byte_at(j))
                hit = 1'b0;
        end
        start = bytes_seen - 32'(len - 1);
        for (int k = REG_PATTERNS - 2; k > 0; k--)
            recent_bytes[k] = recent_bytes[k-1];
        recent_bytes[0] = b;
        // The counter holds at its ceiling rather than wrapping.
        if (bytes_seen != '1)
            bytes_seen++;
        if (hit)
        begin
            r.found = 1'b1;
            r.offset = start;
            await_report(r);
            if (is_last)
                rearm_shadow();
            else
                match_reported = 1'b1;
        end
        else if (is_last)
        begin
            r.found = 1'b0;
            r.offset = '0;
            await_report(r);
            rearm_shadow();
        end
    endtask

    // Compare every accepted result word against the oldest report still awaited.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, got found=%0d offset=%0d",
                         $time, found, match_offset);
            end
            else
            begin
                next_awaited = awaited_results.pop_front();
                if (found !== next_awaited.found)
                begin
                    errors++;
                    $display("%0t: found mismatch, expected %0d, got %0d",
                             $time, next_awaited.found, found);
                end
                if (match_offset !== next_awaited.offset)
                begin
                    errors++;
                    $display("%0t: match_offset mismatch, expected %0d, got %0d",
                             $time, next_awaited.offset, match_offset);
                end
            end
        end
    end

    // Offer one byte word, idling now and then first, and hold it until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        image_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_scan(b, is_last);
    endtask

    // Drop valid and hold off until every awaited report is in and the pipe has settled.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the access edge.
    task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_PAT_LOW:  shadow_cfg.pat_low = value;
            REG_PAT_HIGH: shadow_cfg.pat_high = value;
            REG_WILD:     shadow_cfg.wild_mask = value[15:0];
            REG_LENGTH:   shadow_cfg.length = value[4:0];
            default:      ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Stream one image of n bytes. Most images carry the pattern at a random spot, with
    // random bytes under the wildcards; some copies have one cared-for byte spoilt.
    task automatic run_image(input int n, input bit hold_midway);
        logic [7:0] img [MAX_IMAGE_BYTES];
        int         len;
        int         pos;
        int         j;
        len = effective_length();
        for (int i = 0; i < n; i++)
            img[i] = 8'($urandom_range(0, 255));
        if (n >= len && $urandom_range(0, 99) < 75)
        begin
            pos = $urandom_range(0, n - len);
            for (j = 0; j < len; j++)
                img[pos + j] = shadow_cfg.wild_mask[j] ? 8'($urandom_range(0, 255))
                                                       : pattern_byte_at(j);
            if ($urandom_range(0, 3) == 0)
            begin
                j = $urandom_range(0, len - 1);
                if (!shadow_cfg.wild_mask[j])
                    img[pos + j] ^= 8'(1 << $urandom_range(0, 7));
            end
        end
        for (int i = 0; i < n; i++)
        begin
            // Starve the scanner mid-image until the result side has fully caught up.
            if (hold_midway && i == n / 2)
                wait_drained();
            send_byte(img[i], i == n - 1);
        end
    endtask

    // Reset values: pattern of zero bytes, length one. A zero as the last byte matches there.
    task automatic test_reset_state();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    // Four-byte pattern with a wildcard in second place.
    task automatic test_wildcard_match();
        apb_write(REG_PAT_LOW, 64'h0123_4567_EFBE_ADDE);
        apb_write(REG_PAT_HIGH, 64'hFEDC_BA98_7654_3210);
        apb_write(REG_WILD, 64'h0000_0000_0000_0002);
        apb_write(REG_LENGTH, 64'd4);
        // Match at the very start; the trailing bytes, last one included, stay silent.
        send_byte(8'hDE, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hDE, 1'b1);
        // Image shorter than the pattern: only the not-found report.
        send_byte(8'hDE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hBE, 1'b1);
        // Pattern ending on the final byte of the image.
        send_byte(8'h01, 1'b0);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hEF, 1'b1);
        // One-byte image, no match.
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Length zero behaves as length one.
    task automatic test_length_zero();
        apb_write(REG_LENGTH, 64'd0);
        send_byte(8'hDE, 1'b1);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    // Random phases, each with its own register setting, extremes among them.
    task automatic test_random_images();
        logic [4:0]  len_sel;
        logic [15:0] mask_sel;
        logic [63:0] lo;
        logic [63:0] hi;
        int          sent;
        int          n;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            mask_sel = 16'($urandom & $urandom & $urandom);
            len_sel = 5'($urandom_range(2, 15));
            case (ph)
                0:
                begin
                    len_sel = 5'd16;
                    mask_sel = '0;
                end
                1:
                begin
                    len_sel = 5'd1;
                    mask_sel = '0;
                end
                2: len_sel = 5'd0;
                3:
                begin
                    len_sel = 5'd31;
                    mask_sel = '1;
                end
                4:
                begin
                    lo = '1;
                    hi = '1;
                end
                5:
                begin
                    lo = '0;
                    hi = '0;
                end
                default: ;
            endcase
            wait_drained();
            calm <= (ph == 6);
            apb_write(REG_PAT_LOW, lo);
            apb_write(REG_PAT_HIGH, hi);
            apb_write(REG_WILD, {48'd0, mask_sel});
            apb_write(REG_LENGTH, {59'd0, len_sel});
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_IMAGE_BYTES)
                                                : $urandom_range(1, 24);
                // Always hold once in phase two; elsewhere now and then.
                run_image(n, (ph == 2 && sent == 0) || $urandom_range(0, 99) < 8);
                sent += n;
            end
            wait_drained();
            calm <= 1'b0;
        end
    endtask

    initial
    begin
        shadow_cfg.pat_low = '0;
        shadow_cfg.pat_high = '0;
        shadow_cfg.wild_mask = '0;
        shadow_cfg.length = 5'd1;
        rearm_shadow();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_wildcard_match();
        test_length_zero();
        test_random_images();

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
